// File: rtl/sqw_pkg.sv
package sqw_pkg;

    // Command codes carried by the cmd field of an input beat.
    localparam logic [2:0] CMD_WRITE        = 3'd0;
    localparam logic [2:0] CMD_READ         = 3'd1;
    localparam logic [2:0] CMD_CLOCK_TICK   = 3'd2;
    localparam logic [2:0] CMD_LENGTH_TICK  = 3'd3;
    localparam logic [2:0] CMD_ENVELOPE_TICK = 3'd4;
    localparam logic [2:0] CMD_SWEEP_TICK   = 3'd5;

    // Register indexes after the address is folded modulo five.
    localparam logic [2:0] REG_SWEEP       = 3'd0;
    localparam logic [2:0] REG_LENGTH_DUTY = 3'd1;
    localparam logic [2:0] REG_ENVELOPE    = 3'd2;
    localparam logic [2:0] REG_PERIOD_LOW  = 3'd3;
    localparam logic [2:0] REG_PERIOD_HIGH = 3'd4;

    localparam logic [31:0] DUTY_PATTERNS_RESET = 32'h7EE1_8180;
    localparam logic [10:0] PERIOD_MAX          = 11'h7FF;
    localparam logic [5:0]  LENGTH_MAX          = 6'h3F;
    localparam logic [3:0]  VOLUME_MAX          = 4'hF;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] reg_address;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       channel_on;
        logic [3:0] sample;
    } result_t;

    // Address nibble modulo five; the largest multiple of five not above it is subtracted.
    function automatic logic [2:0] reg_index(input logic [3:0] address);
        logic [3:0] folded;
        begin
            if (address >= 4'd15) begin
                folded = address - 4'd15;
            end else if (address >= 4'd10) begin
                folded = address - 4'd10;
            end else if (address >= 4'd5) begin
                folded = address - 4'd5;
            end else begin
                folded = address;
            end
            reg_index = folded[2:0];
        end
    endfunction

endpackage

// File: rtl/sqw_channel.sv
module sqw_channel #(
    parameter int CLOCK_DIVIDE = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_write_enable,
    input  logic [31:0]       cfg_write_data,
    input  logic              exec_valid,
    input  sqw_pkg::item_t    item,
    output sqw_pkg::result_t  result
);

    localparam int DIV_W = (CLOCK_DIVIDE > 1) ? $clog2(CLOCK_DIVIDE) : 1;
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(CLOCK_DIVIDE - 1);

    logic [31:0]      duty_patterns_reg;
    logic [7:0]       sweep_setting_reg, sweep_setting_next;
    logic [7:0]       length_duty_reg, length_duty_next;
    logic [7:0]       envelope_setting_reg, envelope_setting_next;
    logic [7:0]       period_low_reg, period_low_next;
    logic [7:0]       period_high_reg, period_high_next;
    logic             enabled_reg, enabled_next;
    logic [3:0]       volume_reg, volume_next;
    logic [10:0]      period_count_reg, period_count_next;
    logic [2:0]       duty_step_reg, duty_step_next;
    logic [DIV_W-1:0] clock_divider_reg, clock_divider_next;
    logic [2:0]       envelope_count_reg, envelope_count_next;
    logic [2:0]       sweep_count_reg, sweep_count_next;
    logic [2:0]       sweep_rate_reg, sweep_rate_next;
    logic [5:0]       length_count_reg, length_count_next;
    logic             length_active_reg, length_active_next;

    logic [2:0]  index;
    logic [10:0] period_value;
    logic [10:0] sweep_delta;
    logic [11:0] sweep_target;
    logic [2:0]  envelope_count_inc;
    logic [2:0]  sweep_count_inc;
    logic [7:0]  read_data;
    logic [7:0]  duty_pattern;

    assign index              = sqw_pkg::reg_index(item.reg_address);
    assign period_value       = {period_high_reg[2:0], period_low_reg};
    assign sweep_delta        = period_value >> sweep_setting_reg[2:0];
    assign sweep_target       = sweep_setting_reg[3] ?
                                ({1'b0, period_value} - {1'b0, sweep_delta}) :
                                ({1'b0, period_value} + {1'b0, sweep_delta});
    assign envelope_count_inc = envelope_count_reg + 3'd1;
    assign sweep_count_inc    = sweep_count_reg + 3'd1;

    always_comb begin
        sweep_setting_next    = sweep_setting_reg;
        length_duty_next      = length_duty_reg;
        envelope_setting_next = envelope_setting_reg;
        period_low_next       = period_low_reg;
        period_high_next      = period_high_reg;
        enabled_next          = enabled_reg;
        volume_next           = volume_reg;
        period_count_next     = period_count_reg;
        duty_step_next        = duty_step_reg;
        clock_divider_next    = clock_divider_reg;
        envelope_count_next   = envelope_count_reg;
        sweep_count_next      = sweep_count_reg;
        sweep_rate_next       = sweep_rate_reg;
        length_count_next     = length_count_reg;
        length_active_next    = length_active_reg;
        read_data             = 8'd0;

        if (exec_valid) begin
            unique case (item.cmd)
                sqw_pkg::CMD_WRITE: begin
                    unique case (index)
                        sqw_pkg::REG_SWEEP:       sweep_setting_next = item.write_data;
                        sqw_pkg::REG_LENGTH_DUTY: length_duty_next = item.write_data;
                        sqw_pkg::REG_ENVELOPE: begin
                            envelope_setting_next = item.write_data;
                            // The DAC is off when bits 7..3 are all clear.
                            if (item.write_data[7:3] == 5'd0) begin
                                enabled_next = 1'b0;
                            end
                        end
                        sqw_pkg::REG_PERIOD_LOW:  period_low_next = item.write_data;
                        default: begin
                            period_high_next = item.write_data;
                            if (item.write_data[7]) begin
                                enabled_next        = 1'b1;
                                volume_next         = envelope_setting_reg[7:4];
                                period_count_next   = {item.write_data[2:0], period_low_reg};
                                duty_step_next      = 3'd0;
                                envelope_count_next = 3'd0;
                                sweep_rate_next     = sweep_setting_reg[6:4];
                            end
                            if (item.write_data[6]) begin
                                length_active_next = 1'b1;
                                length_count_next  = length_duty_reg[5:0];
                            end
                        end
                    endcase
                end
                sqw_pkg::CMD_READ: begin
                    unique case (index)
                        sqw_pkg::REG_SWEEP:       read_data = sweep_setting_reg;
                        sqw_pkg::REG_LENGTH_DUTY: read_data = length_duty_reg;
                        sqw_pkg::REG_ENVELOPE:    read_data = envelope_setting_reg;
                        sqw_pkg::REG_PERIOD_LOW:  read_data = period_low_reg;
                        default:                  read_data = period_high_reg;
                    endcase
                end
                sqw_pkg::CMD_CLOCK_TICK: begin
                    if (enabled_reg) begin
                        if (clock_divider_reg == DIV_LAST) begin
                            clock_divider_next = '0;
                            if (period_count_reg == sqw_pkg::PERIOD_MAX) begin
                                duty_step_next    = duty_step_reg + 3'd1;
                                period_count_next = period_value;
                            end else begin
                                period_count_next = period_count_reg + 11'd1;
                            end
                        end else begin
                            clock_divider_next = clock_divider_reg + DIV_W'(1);
                        end
                    end
                end
                sqw_pkg::CMD_LENGTH_TICK: begin
                    if (length_active_reg && enabled_reg) begin
                        if (length_count_reg == sqw_pkg::LENGTH_MAX) begin
                            length_active_next = 1'b0;
                            enabled_next       = 1'b0;
                        end else begin
                            length_count_next = length_count_reg + 6'd1;
                        end
                    end
                end
                sqw_pkg::CMD_ENVELOPE_TICK: begin
                    if (enabled_reg && (envelope_setting_reg[2:0] != 3'd0)) begin
                        // A pace lowered below the running count fires at once.
                        if ((envelope_count_inc != 3'd0) &&
                            (envelope_count_inc < envelope_setting_reg[2:0])) begin
                            envelope_count_next = envelope_count_inc;
                        end else begin
                            envelope_count_next = 3'd0;
                            if (envelope_setting_reg[3]) begin
                                if (volume_reg != sqw_pkg::VOLUME_MAX) begin
                                    volume_next = volume_reg + 4'd1;
                                end
                            end else if (volume_reg != 4'd0) begin
                                volume_next = volume_reg - 4'd1;
                            end
                        end
                    end
                end
                sqw_pkg::CMD_SWEEP_TICK: begin
                    if (enabled_reg && (sweep_rate_reg != 3'd0)) begin
                        if ((sweep_count_inc != 3'd0) && (sweep_count_inc < sweep_rate_reg)) begin
                            sweep_count_next = sweep_count_inc;
                        end else begin
                            sweep_count_next = 3'd0;
                            sweep_rate_next  = sweep_setting_reg[6:4];
                            // An upward sweep past the 11-bit range stops the channel.
                            if (!sweep_setting_reg[3] && sweep_target[11]) begin
                                enabled_next = 1'b0;
                            end else begin
                                period_low_next  = sweep_target[7:0];
                                period_high_next = {period_high_reg[7:3], sweep_target[10:8]};
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign duty_pattern = duty_patterns_reg[{length_duty_next[7:6], 3'b000} +: 8];

    always_comb begin
        result.read_data  = read_data;
        result.channel_on = enabled_next;
        result.sample     = (enabled_next && duty_pattern[duty_step_next]) ? volume_next : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_patterns_reg    <= sqw_pkg::DUTY_PATTERNS_RESET;
            sweep_setting_reg    <= 8'd0;
            length_duty_reg      <= 8'd0;
            envelope_setting_reg <= 8'd0;
            period_low_reg       <= 8'd0;
            period_high_reg      <= 8'd0;
            enabled_reg          <= 1'b0;
            volume_reg           <= 4'd0;
            period_count_reg     <= 11'd0;
            duty_step_reg        <= 3'd0;
            clock_divider_reg    <= '0;
            envelope_count_reg   <= 3'd0;
            sweep_count_reg      <= 3'd0;
            sweep_rate_reg       <= 3'd0;
            length_count_reg     <= 6'd0;
            length_active_reg    <= 1'b0;
        end else begin
            if (cfg_write_enable) begin
                duty_patterns_reg <= cfg_write_data;
            end
            sweep_setting_reg    <= sweep_setting_next;
            length_duty_reg      <= length_duty_next;
            envelope_setting_reg <= envelope_setting_next;
            period_low_reg       <= period_low_next;
            period_high_reg      <= period_high_next;
            enabled_reg          <= enabled_next;
            volume_reg           <= volume_next;
            period_count_reg     <= period_count_next;
            duty_step_reg        <= duty_step_next;
            clock_divider_reg    <= clock_divider_next;
            envelope_count_reg   <= envelope_count_next;
            sweep_count_reg      <= sweep_count_next;
            sweep_rate_reg       <= sweep_rate_next;
            length_count_reg     <= length_count_next;
            length_active_reg    <= length_active_next;
        end
    end

    // Channel state only moves on an executed beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !exec_valid |=> $stable(volume_reg) && $stable(period_count_reg) &&
                        $stable(duty_step_reg) && $stable(enabled_reg))
        else $error("channel state changed without an executed beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        clock_divider_reg <= DIV_LAST)
        else $error("clock divider out of range");

    // Length expiry must take the channel down with it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(length_active_reg) |-> !enabled_reg)
        else $error("length expired but channel still enabled");

endmodule

// File: rtl/square_wave_sound_channel.sv
// Channel  | Handshake           | Payload
// s_       | s_valid / s_ready   | s_cmd, s_reg_address, s_write_data
// m_       | m_valid / m_ready   | m_read_data, m_channel_on, m_sample
// cfg_     | cfg_write_enable    | cfg_write_data (duty patterns)
//
// Each command beat is taken into an input register and executed against the channel
// state; the result register loads when the beat executes and drives the m_ ports.
// One beat is accepted every cycle while m_ready is high; the state update of one beat
// is the loop that sets this rate, and it is combinational.
// Reset is synchronous and active low; it restores the power-on duty patterns.
// When m_ready is low the result register holds and the input register fills; s_ready
// then drops until the result is taken.
module square_wave_sound_channel #(
    parameter int CLOCK_DIVIDE = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write_enable,
    input  logic [31:0] cfg_write_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [3:0]  s_reg_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_channel_on,
    output logic [3:0]  m_sample
);

    logic               in_valid_reg;
    sqw_pkg::item_t     item_reg;
    logic               out_valid_reg;
    sqw_pkg::result_t   result_reg;
    sqw_pkg::result_t   result_next;
    logic               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sqw_channel #(
        .CLOCK_DIVIDE (CLOCK_DIVIDE)
    ) u_channel (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .exec_valid       (advance),
        .item             (item_reg),
        .result           (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= {s_cmd, s_reg_address, s_write_data};
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_data  = result_reg.read_data;
    assign m_channel_on = result_reg.channel_on;
    assign m_sample     = result_reg.sample;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_channel_on |-> m_sample == 4'd0)
        else $error("sample nonzero on a disabled channel");

    // A held result must not be overwritten by a new execution.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule
